// File: sv/tick_divider_debounce_countdowns_macros.svh
// assertion macros for the tick divider block
`ifndef TICK_DIVIDER_DEBOUNCE_COUNTDOWNS_MACROS_SVH
`define TICK_DIVIDER_DEBOUNCE_COUNTDOWNS_MACROS_SVH

// same-cycle implication, checked outside reset
`define TDD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tdd_pkg.sv
// shared types and constants of the tick divider block
package tdd_pkg;

    localparam int COUNT_W = 15;
    localparam int DIV_W   = 8;
    localparam int ADDR_W  = 3;
    localparam int APB_W   = 32;

    localparam logic [DIV_W-1:0] FAST_RELOAD_RST = 8'd5;
    localparam logic [DIV_W-1:0] SLOW_RELOAD_RST = 8'd50;

    localparam logic [31:0] PRESS_PATTERN = 32'h0000_000F;

    localparam logic REG_FAST_RELOAD = 1'b0;
    localparam logic REG_SLOW_RELOAD = 1'b1;

    typedef enum logic [1:0] {
        FUNC_TICK       = 2'd0,
        FUNC_LOAD_REACT = 2'd1,
        FUNC_LOAD_DISP  = 2'd2,
        FUNC_CLEAR      = 2'd3
    } t_func;

    typedef struct packed {
        logic [DIV_W-1:0] fast;
        logic [DIV_W-1:0] slow;
    } t_reload;

    typedef struct packed {
        logic slow_event;
        logic fast_event;
        logic strobe_res;
    } t_events;

endpackage

// File: sv/tick_divider_debounce_countdowns.sv
// Tick divider with shift-register button debounce and two countdowns. Each item
// is taken into an input register, processed by one pass of counter and shift
// logic, and its result is held in an output register; one item is accepted every
// clock cycle while the output side keeps up, and a result moves from the input
// register into the output register once the output register is empty or being
// read. A stalled output holds one result and one more item may wait in the
// input register. The divider reload values sit behind the apb port and should be
// written only while no items are in flight.
`include "tick_divider_debounce_countdowns_macros.svh"

module tick_divider_debounce_countdowns
    import tdd_pkg::*;
#(
    parameter int BUTTON_COUNT = 4,
    parameter int HISTORY_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // buttons, value, zero fill
    input  logic [((BUTTON_COUNT+COUNT_W+7)/8)*8-1:0] s_axis_tdata,
    // func
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // pressed, reaction_count, display_count, zero fill
    output logic [((BUTTON_COUNT+2*COUNT_W+7)/8)*8-1:0] m_axis_tdata,
    // strobe_res, fast_event, slow_event
    output logic [2:0]        m_axis_tuser,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    localparam int OUT_W     = BUTTON_COUNT + 2 * COUNT_W;
    localparam int OUT_BYTES = ((OUT_W + 7) / 8) * 8;

    t_reload                 w_reload;
    t_events                 w_events;
    logic [BUTTON_COUNT-1:0] w_pressed;
    logic [COUNT_W-1:0]      w_reaction, w_display;
    logic                    w_advance;

    logic                    r_in_valid;
    t_func                   r_in_func;
    logic [BUTTON_COUNT-1:0] r_in_buttons;
    logic [COUNT_W-1:0]      r_in_value;

    logic                    r_out_valid;
    t_events                 r_out_events;
    logic [BUTTON_COUNT-1:0] r_out_pressed;
    logic [COUNT_W-1:0]      r_out_reaction, r_out_display;

    tdd_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_reload (w_reload)
    );

    tdd_state #(
        .BUTTON_COUNT (BUTTON_COUNT),
        .HISTORY_BITS (HISTORY_BITS)
    ) u_state (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_advance),
        .i_func           (r_in_func),
        .i_buttons        (r_in_buttons),
        .i_value          (r_in_value),
        .i_reload         (w_reload),
        .o_events         (w_events),
        .o_pressed        (w_pressed),
        .o_reaction_count (w_reaction),
        .o_display_count  (w_display)
    );

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func    <= t_func'(s_axis_tuser);
            r_in_buttons <= s_axis_tdata[BUTTON_COUNT-1:0];
            r_in_value   <= s_axis_tdata[BUTTON_COUNT+COUNT_W-1:BUTTON_COUNT];
        end
        if (w_advance) begin
            r_out_events   <= w_events;
            r_out_pressed  <= w_pressed;
            r_out_reaction <= w_reaction;
            r_out_display  <= w_display;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out_events.slow_event, r_out_events.fast_event,
                            r_out_events.strobe_res};
    assign m_axis_tdata  = {{(OUT_BYTES-OUT_W){1'b0}}, r_out_display, r_out_reaction,
                            r_out_pressed};

    `TDD_ASSERT_NOW(a_stall_blocks_input,
        r_in_valid && r_out_valid && !m_axis_tready, !s_axis_tready,
        "input taken while both stages are full")
    `TDD_ASSERT_NEXT(a_advance_fills_output, w_advance, r_out_valid,
        "processed item did not reach the output register")
    `TDD_ASSERT_NOW(a_slow_needs_fast, m_axis_tvalid && !m_axis_tuser[1], !m_axis_tuser[2],
        "slow event without fast event")
    `TDD_ASSERT_NOW(a_event_needs_tick, m_axis_tvalid && !m_axis_tuser[0], !m_axis_tuser[1],
        "fast event on a result that is not a tick")

endmodule

// File: sv/tdd_cfg.sv
// apb register file for the divider reload values
module tdd_cfg
    import tdd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    output t_reload           o_reload
);

    t_reload r_reload;
    logic    w_wr;
    logic    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[ADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload.fast <= FAST_RELOAD_RST;
            r_reload.slow <= SLOW_RELOAD_RST;
        end else if (w_wr) begin
            if (w_idx == REG_FAST_RELOAD) begin
                r_reload.fast <= pwdata[DIV_W-1:0];
            end else begin
                r_reload.slow <= pwdata[DIV_W-1:0];
            end
        end
    end

    always_comb begin
        if (w_idx == REG_SLOW_RELOAD) begin
            prdata = {{(APB_W-DIV_W){1'b0}}, r_reload.slow};
        end else begin
            prdata = {{(APB_W-DIV_W){1'b0}}, r_reload.fast};
        end
    end

    assign o_reload = r_reload;

endmodule

// File: sv/tdd_state.sv
// dividers, countdowns, debounce histories and press flags with their next-state logic
module tdd_state
    import tdd_pkg::*;
#(
    parameter int BUTTON_COUNT = 4,
    parameter int HISTORY_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  t_func                   i_func,
    input  logic [BUTTON_COUNT-1:0] i_buttons,
    input  logic [COUNT_W-1:0]      i_value,
    input  t_reload                 i_reload,
    output t_events                 o_events,
    output logic [BUTTON_COUNT-1:0] o_pressed,
    output logic [COUNT_W-1:0]      o_reaction_count,
    output logic [COUNT_W-1:0]      o_display_count
);

    logic [DIV_W-1:0]        r_fast_div, n_fast_div;
    logic [DIV_W-1:0]        r_slow_div, n_slow_div;
    logic [COUNT_W-1:0]      r_reaction, n_reaction;
    logic [COUNT_W-1:0]      r_display,  n_display;
    logic [HISTORY_BITS-1:0] r_hist [BUTTON_COUNT];
    logic [HISTORY_BITS-1:0] n_hist [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] r_flags, n_flags;
    logic                    w_tick, w_fast, w_slow;

    assign w_tick = (i_func == FUNC_TICK);
    assign w_fast = w_tick && (r_fast_div == DIV_W'(1));
    assign w_slow = w_fast && (r_slow_div == DIV_W'(1));

    always_comb begin
        n_fast_div = r_fast_div;
        n_slow_div = r_slow_div;
        n_reaction = r_reaction;
        n_display  = r_display;
        n_flags    = r_flags;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            n_hist[i] = r_hist[i];
        end
        case (i_func)
            FUNC_TICK: begin
                n_fast_div = w_fast ? i_reload.fast : r_fast_div - DIV_W'(1);
                if (w_fast) begin
                    n_slow_div = w_slow ? i_reload.slow : r_slow_div - DIV_W'(1);
                    if (r_reaction != '0) begin
                        n_reaction = r_reaction - COUNT_W'(1);
                    end
                    for (int i = 0; i < BUTTON_COUNT; i++) begin
                        n_hist[i] = {r_hist[i][HISTORY_BITS-2:0], i_buttons[i]};
                        if (n_hist[i] == PRESS_PATTERN[HISTORY_BITS-1:0]) begin
                            n_flags[i] = 1'b1;
                        end
                    end
                end
                if (w_slow && (r_display != '0)) begin
                    n_display = r_display - COUNT_W'(1);
                end
            end
            FUNC_LOAD_REACT: n_reaction = i_value;
            FUNC_LOAD_DISP:  n_display  = i_value;
            FUNC_CLEAR:      n_flags    = r_flags & ~i_value[BUTTON_COUNT-1:0];
            default:         n_flags    = r_flags;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_div <= FAST_RELOAD_RST;
            r_slow_div <= SLOW_RELOAD_RST;
            r_reaction <= '0;
            r_display  <= '0;
            r_flags    <= '0;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_step) begin
            r_fast_div <= n_fast_div;
            r_slow_div <= n_slow_div;
            r_reaction <= n_reaction;
            r_display  <= n_display;
            r_flags    <= n_flags;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_hist[i] <= n_hist[i];
            end
        end
    end

    assign o_events.strobe_res = w_tick;
    assign o_events.fast_event = w_fast;
    assign o_events.slow_event = w_slow;
    assign o_pressed           = n_flags;
    assign o_reaction_count    = n_reaction;
    assign o_display_count     = n_display;

endmodule

// File: tb/tb_tick_divider_debounce_countdowns.sv
// testbench for the tick divider, debounce and countdown block
`timescale 1ns / 100ps

module tb_tick_divider_debounce_countdowns
    import tdd_pkg::*;
();

    localparam int BUTTONS   = 4;
    localparam int HIST_W    = 16;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 40;
    localparam int NUM_PHASE = 5;

    localparam logic [ADDR_W-1:0] ADDR_FAST = ADDR_W'(4 * int'(REG_FAST_RELOAD));
    localparam logic [ADDR_W-1:0] ADDR_SLOW = ADDR_W'(4 * int'(REG_SLOW_RELOAD));

    typedef struct {
        t_events               ev;
        logic [BUTTONS-1:0]    pressed;
        logic [COUNT_W-1:0]    react;
        logic [COUNT_W-1:0]    disp;
    } t_tick_result;

    class tick_tracker;
        t_tick_result        due_results[$];
        logic [DIV_W-1:0]    fast_rl;
        logic [DIV_W-1:0]    slow_rl;
        logic [DIV_W-1:0]    fast_div;
        logic [DIV_W-1:0]    slow_div;
        logic [COUNT_W-1:0]  react_cnt;
        logic [COUNT_W-1:0]  disp_cnt;
        logic [HIST_W-1:0]   history [BUTTONS];
        logic [BUTTONS-1:0]  flags;
        int                  errors;
        int                  checked;
        int                  fast_seen;
        int                  slow_seen;
        int                  press_seen;

        function new();
            fast_rl   = FAST_RELOAD_RST;
            slow_rl   = SLOW_RELOAD_RST;
            fast_div  = FAST_RELOAD_RST;
            slow_div  = SLOW_RELOAD_RST;
            react_cnt = '0;
            disp_cnt  = '0;
            flags     = '0;
            foreach (history[i]) history[i] = '0;
            errors    = 0;
            checked   = 0;
            fast_seen = 0;
            slow_seen = 0;
            press_seen = 0;
        endfunction

        function void set_reload(logic sel, logic [DIV_W-1:0] v);
            if (sel == REG_FAST_RELOAD) begin
                fast_rl = v;
            end else begin
                slow_rl = v;
            end
        endfunction

        function void note_item(t_func f, logic [BUTTONS-1:0] btn, logic [COUNT_W-1:0] val);
            t_tick_result r;
            r.ev = '0;
            case (f)
                FUNC_TICK: begin
                    r.ev.strobe_res = 1'b1;
                    fast_div = fast_div - DIV_W'(1);
                    if (fast_div == '0) begin
                        fast_div = fast_rl;
                        r.ev.fast_event = 1'b1;
                        fast_seen++;
                        if (react_cnt != '0) react_cnt = react_cnt - COUNT_W'(1);
                        for (int i = 0; i < BUTTONS; i++) begin
                            history[i] = {history[i][HIST_W-2:0], btn[i]};
                            if (history[i] == PRESS_PATTERN[HIST_W-1:0]) begin
                                if (!flags[i]) press_seen++;
                                flags[i] = 1'b1;
                            end
                        end
                        slow_div = slow_div - DIV_W'(1);
                        if (slow_div == '0) begin
                            slow_div = slow_rl;
                            r.ev.slow_event = 1'b1;
                            slow_seen++;
                            if (disp_cnt != '0) disp_cnt = disp_cnt - COUNT_W'(1);
                        end
                    end
                end
                FUNC_LOAD_REACT: react_cnt = val;
                FUNC_LOAD_DISP:  disp_cnt = val;
                default:         flags = flags & ~val[BUTTONS-1:0];
            endcase
            r.pressed = flags;
            r.react   = react_cnt;
            r.disp    = disp_cnt;
            due_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [2:0] user, logic [OUT_W-1:0] data);
            t_tick_result want;
            t_events      got_ev;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0h/%0h",
                         $time, user, data);
            end else begin
                want   = due_results.pop_front();
                got_ev = user;
                checked++;
                compare_field("strobe_res", 32'(want.ev.strobe_res), 32'(got_ev.strobe_res));
                compare_field("fast_event", 32'(want.ev.fast_event), 32'(got_ev.fast_event));
                compare_field("slow_event", 32'(want.ev.slow_event), 32'(got_ev.slow_event));
                compare_field("pressed", 32'(want.pressed), 32'(data[3:0]));
                compare_field("reaction_count", 32'(want.react), 32'(data[18:4]));
                compare_field("display_count", 32'(want.disp), 32'(data[33:19]));
            end
        endfunction

        function int waiting();
            return due_results.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;
    logic [1:0]         s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic [2:0]         m_axis_tuser;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [APB_W-1:0]   pwdata;
    logic [APB_W-1:0]   prdata;
    logic               pready;

    tick_tracker        sb;
    bit                 hold_req;
    int                 items_sent;
    int                 cur_fast;
    bit                 btn_level [BUTTONS];
    int                 btn_left  [BUTTONS];

    int phase_fast  [NUM_PHASE] = '{1, 2, 1, 0, 255};
    int phase_slow  [NUM_PHASE] = '{1, 3, 255, 1, 255};
    int phase_items [NUM_PHASE] = '{100, 100, 100, 290, 60};
    int phase_tick  [NUM_PHASE] = '{75, 75, 75, 95, 75};

    tick_divider_debounce_countdowns u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 6);
        return $urandom_range(15, 40);
    endfunction

    // button levels held in runs long enough to form released-then-pressed histories
    function automatic logic [BUTTONS-1:0] next_buttons();
        logic [BUTTONS-1:0] lv;
        int                 scale;
        scale = (cur_fast == 0) ? 256 : cur_fast;
        for (int i = 0; i < BUTTONS; i++) begin
            if (btn_left[i] == 0) begin
                btn_level[i] = !btn_level[i];
                if (btn_level[i]) begin
                    btn_left[i] = $urandom_range(3, 7) * scale;
                end else begin
                    btn_left[i] = $urandom_range(12, 18) * scale;
                end
            end
            btn_left[i]--;
            lv[i] = btn_level[i];
        end
        if ($urandom_range(0, 9) == 0) lv = BUTTONS'($urandom_range(0, 15));
        return lv;
    endfunction

    task automatic send_item(input t_func f, input logic [BUTTONS-1:0] btn,
                             input logic [COUNT_W-1:0] val, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {5'b0, val, btn};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(f, btn, val);
        items_sent++;
    endtask

    task automatic random_item(input int tick_pct);
        int                 r;
        int                 gap;
        logic [COUNT_W-1:0] val;
        r   = $urandom_range(0, 99);
        gap = ($urandom_range(0, 9) < 6) ? 0 : gap_len();
        val = ($urandom_range(0, 9) < 6) ? COUNT_W'($urandom_range(0, 20))
                                         : COUNT_W'($urandom_range(0, 32767));
        if (r < tick_pct) begin
            send_item(FUNC_TICK, next_buttons(), COUNT_W'($urandom_range(0, 32767)), gap);
        end else if (r < tick_pct + (100 - tick_pct) / 3) begin
            send_item(FUNC_LOAD_REACT, BUTTONS'($urandom_range(0, 15)), val, gap);
        end else if (r < tick_pct + 2 * (100 - tick_pct) / 3) begin
            send_item(FUNC_LOAD_DISP, BUTTONS'($urandom_range(0, 15)), val, gap);
        end else begin
            send_item(FUNC_CLEAR, BUTTONS'($urandom_range(0, 15)),
                      COUNT_W'($urandom_range(0, 32767)), gap);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.waiting() != 0);
    endtask

    task automatic write_reg(input logic sel, input logic [DIV_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= (sel == REG_FAST_RELOAD) ? ADDR_FAST : ADDR_SLOW;
        pwdata  <= APB_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reload(sel, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    initial begin
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (120) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(30, 60)) @(posedge i_clk);
                end else begin
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
                if ($urandom_range(0, 3) != 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap_len()) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        sb            = new();
        hold_req      = 1'b0;
        items_sent    = 0;
        cur_fast      = int'(FAST_RELOAD_RST);
        foreach (btn_level[i]) begin
            btn_level[i] = 1'b1;
            btn_left[i]  = 0;
        end
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_TICK;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, every func, reaction countdown hitting zero
        send_item(FUNC_LOAD_REACT, 4'h0, 15'd0, 0);
        send_item(FUNC_LOAD_REACT, 4'hF, 15'h7FFF, 0);
        send_item(FUNC_LOAD_DISP, 4'h0, 15'h7FFF, 0);
        send_item(FUNC_LOAD_DISP, 4'hF, 15'd0, 1);
        send_item(FUNC_CLEAR, 4'h0, 15'h7FFF, 0);
        send_item(FUNC_CLEAR, 4'hF, 15'd0, 0);
        for (int i = 0; i < 6; i++) send_item(FUNC_TICK, 4'hF, 15'h7FFF, 0);
        send_item(FUNC_LOAD_REACT, 4'h5, 15'd1, 0);
        send_item(FUNC_LOAD_DISP, 4'hA, 15'd1, 0);
        for (int i = 0; i < 6; i++) send_item(FUNC_TICK, 4'h0, 15'd0, 2);
        send_item(FUNC_CLEAR, 4'hA, 15'h5555, 0);
        send_item(FUNC_TICK, 4'h5, 15'h2AAA, 0);
        send_item(FUNC_TICK, 4'hA, 15'h5555, 0);

        for (int ph = 0; ph < NUM_PHASE; ph++) begin
            drain();
            write_reg(REG_FAST_RELOAD, DIV_W'(phase_fast[ph]));
            write_reg(REG_SLOW_RELOAD, DIV_W'(phase_slow[ph]));
            cur_fast = phase_fast[ph];
            for (int n = 0; n < phase_items[ph]; n++) begin
                if (ph == 1 && n == 20) hold_req = 1'b1;
                random_item(phase_tick[ph]);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("run covered %0d items and %0d checked results, %0d fast and %0d slow events",
                 items_sent, sb.checked, sb.fast_seen, sb.slow_seen);
        $display("%0d debounced presses, reloads of 1, 255 and zero, one long output stall",
                 sb.press_seen);
        if (sb.errors == 0 && sb.waiting() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
